/* src/bls_pkg.sv */
// Shared types, constants and helpers for the bilinear RGB565 scaler.
// No dependencies; the top level, bls_div and bls_blend import this package.
package bls_pkg;

  localparam int COORD_W = 9;
  localparam int SCALE_W = 9;
  localparam int PIX_W   = 16;
  localparam int LIM_W   = 18;
  localparam int PCT_W   = 7;

  localparam logic [SCALE_W-1:0] SCALE_MIN   = 9'd25;
  localparam logic [SCALE_W-1:0] SCALE_MAX   = 9'd400;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 9'd100;
  localparam logic [PCT_W-1:0]   PERCENT     = 7'd100;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef struct packed {
    logic                 vld;
    logic                 is_load;
    logic                 inr;
    logic [PIX_W-1:0]     pix;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
  } pl_t;

  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
    logic [SCALE_W-1:0] r;
    r = s;
    if (r < SCALE_MIN) r = SCALE_MIN;
    if (r > SCALE_MAX) r = SCALE_MAX;
    return r;
  endfunction

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [SCALE_W:0] div_step(input logic [SCALE_W-1:0] rem,
                                                input logic nbit,
                                                input logic [SCALE_W-1:0] s);
    logic [SCALE_W:0] t;
    logic [SCALE_W:0] d;
    t = {rem, nbit};
    d = t - {1'b0, s};
    if (t >= {1'b0, s}) return {1'b1, d[SCALE_W-1:0]};
    else return {1'b0, t[SCALE_W-1:0]};
  endfunction

endpackage

/* src/bilinear_rgb565_scaler.sv */
// Top level of the bilinear RGB565 scaler: frame store banks, divider, blend.
// Depends on bls_pkg, bls_ram, bls_div and bls_blend.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------
//  req      | req_valid / req_stall  | func, row, col, pixel_in
//  rsp      | rsp_valid / rsp_stall  | pixel_out, in_range
//  cfg      | cfg_we                 | cfg_wdata (scale_percent)
//
// One transaction per clock in both directions while no result is stalled.
// Each accepted request passes through the bit-per-stage divider, NW =
// 16 + FRAC_BITS stages deep, that maps output coordinates back to source
// positions, then the frame store read, the blend and the output register.
// The frame store is four banks split by row and column parity, so all four
// neighbours are read in one cycle. Loads write at the same stage samples
// read, so program order holds with no forwarding.
// Reset (rst, synchronous) clears valids and sets the scale to 100; the
// store contents stay undefined until loaded. A stalled result freezes the
// whole pipeline and req_stall rises in the same cycle.
module bilinear_rgb565_scaler #(
  parameter int SRC_HEIGHT = 128,
  parameter int SRC_WIDTH  = 128,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         func,
  input  logic [bls_pkg::COORD_W-1:0]  row,
  input  logic [bls_pkg::COORD_W-1:0]  col,
  input  logic [bls_pkg::PIX_W-1:0]    pixel_in,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [bls_pkg::PIX_W-1:0]    pixel_out,
  output logic                         in_range,
  input  logic                         cfg_we,
  input  logic [bls_pkg::SCALE_W-1:0]  cfg_wdata
);
  import bls_pkg::*;

  localparam int NW    = COORD_W + PCT_W + FRAC_BITS;
  localparam int CH    = (SRC_HEIGHT + 1) / 2;
  localparam int CW    = (SRC_WIDTH + 1) / 2;
  localparam int BDEP  = CH * CW;
  localparam int AW    = (BDEP > 1) ? $clog2(BDEP) : 1;
  localparam int BDEPR = 1 << AW;
  localparam int AXW   = 2 * COORD_W;
  localparam logic [COORD_W-1:0] HMAX = COORD_W'(SRC_HEIGHT - 1);
  localparam logic [COORD_W-1:0] WMAX = COORD_W'(SRC_WIDTH - 1);

  // Scale register and its clamped value; the user must keep it stable while items are in flight (not enforced here).
  logic [SCALE_W-1:0] scale_percent;
  logic [SCALE_W-1:0] s;

  always_ff @(posedge clk) begin
    if (rst) scale_percent <= SCALE_RESET;
    else if (cfg_we) scale_percent <= cfg_wdata;
  end

  assign s = eff_scale(scale_percent);

  // Advance everything unless a finished result is held by the consumer.
  logic adv;
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  // Range checks at the input: row < floor(H*s/100) <=> 100*(row+1) <= H*s.
  logic [LIM_W-1:0] lim_h, lim_w, need_r, need_c;
  logic             smp_inr, ld_inr, is_load;
  logic [COORD_W+PCT_W-1:0] row_pct, col_pct;

  assign lim_h   = LIM_W'(SRC_HEIGHT) * LIM_W'(s);
  assign lim_w   = LIM_W'(SRC_WIDTH) * LIM_W'(s);
  assign need_r  = (LIM_W'(row) + LIM_W'(1)) * LIM_W'(PERCENT);
  assign need_c  = (LIM_W'(col) + LIM_W'(1)) * LIM_W'(PERCENT);
  assign smp_inr = (need_r <= lim_h) && (need_c <= lim_w);
  assign ld_inr  = ({1'b0, row} < (COORD_W+1)'(SRC_HEIGHT)) &&
                   ({1'b0, col} < (COORD_W+1)'(SRC_WIDTH));
  assign is_load = (func == FUNC_LOAD);
  assign row_pct = (COORD_W+PCT_W)'(row) * (COORD_W+PCT_W)'(PERCENT);
  assign col_pct = (COORD_W+PCT_W)'(col) * (COORD_W+PCT_W)'(PERCENT);

  // Payload travels alongside the divider stages.
  pl_t pl_d [0:NW];

  always_ff @(posedge clk) begin
    if (rst) pl_d[0] <= '0;
    else if (adv) begin
      pl_d[0].vld     <= req_valid;
      pl_d[0].is_load <= is_load;
      pl_d[0].inr     <= is_load ? ld_inr : smp_inr;
      pl_d[0].pix     <= pixel_in;
      pl_d[0].row     <= row;
      pl_d[0].col     <= col;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_pl
    always_ff @(posedge clk) begin
      if (rst) pl_d[k+1] <= '0;
      else if (adv) pl_d[k+1] <= pl_d[k];
    end
  end

  logic [NW-1:0] qr, qc;

  bls_div #(.NW(NW)) u_div_row (
    .clk (clk), .en (adv), .s (s),
    .num ({row_pct, {FRAC_BITS{1'b0}}}), .quo (qr)
  );

  bls_div #(.NW(NW)) u_div_col (
    .clk (clk), .en (adv), .s (s),
    .num ({col_pct, {FRAC_BITS{1'b0}}}), .quo (qc)
  );

  // Neighbour coordinates with edge clamping.
  pl_t                pl_n;
  logic [NW-FRAC_BITS-1:0] r0f, c0f;
  logic [COORD_W-1:0] r0, r1, c0, c1;

  assign pl_n = pl_d[NW];
  assign r0f  = qr[NW-1:FRAC_BITS];
  assign c0f  = qc[NW-1:FRAC_BITS];
  assign r0   = (r0f > (NW-FRAC_BITS)'(HMAX)) ? HMAX : r0f[COORD_W-1:0];
  assign c0   = (c0f > (NW-FRAC_BITS)'(WMAX)) ? WMAX : c0f[COORD_W-1:0];
  assign r1   = (r0 == HMAX) ? r0 : r0 + COORD_W'(1);
  assign c1   = (c0 == WMAX) ? c0 : c0 + COORD_W'(1);

  // Bank index = {row parity, column parity}.
  logic [PIX_W-1:0] rd [0:3];
  logic [3:0]       bank_we;

  for (genvar bk = 0; bk < 4; bk++) begin : g_bank
    localparam logic [1:0] BK = 2'(bk);
    logic [COORD_W-1:0] rs, cs;
    logic [AXW-1:0]     ax;
    logic [AW-1:0]      addr;

    always_comb begin
      if (pl_n.is_load) begin
        rs = pl_n.row;
        cs = pl_n.col;
      end else begin
        rs = (r0[0] == BK[1]) ? r0 : r1;
        cs = (c0[0] == BK[0]) ? c0 : c1;
      end
    end

    assign ax   = AXW'(rs[COORD_W-1:1]) * AXW'(CW) + AXW'(cs[COORD_W-1:1]);
    assign addr = ax[AW-1:0];
    assign bank_we[bk] = adv && pl_n.vld && pl_n.is_load && pl_n.inr &&
                         (pl_n.row[0] == BK[1]) && (pl_n.col[0] == BK[0]);

    bls_ram #(.WIDTH(PIX_W), .DEPTH(BDEPR)) u_ram (
      .clk   (clk),
      .we    (bank_we[bk]),
      .waddr (addr),
      .wdata (pl_n.pix),
      .re    (adv),
      .raddr (addr),
      .rdata (rd[bk])
    );
  end

  // Hold neighbour parities and fractions for the cycle the RAM reads.
  pl_t                pl_m, pl_b1, pl_b2;
  logic               r0p, r1p, c0p, c1p;
  logic [FRAC_BITS-1:0] fa, fb;

  always_ff @(posedge clk) begin
    if (rst) begin
      pl_m  <= '0;
      pl_b1 <= '0;
      pl_b2 <= '0;
    end else if (adv) begin
      pl_m  <= pl_n;
      pl_b1 <= pl_m;
      pl_b2 <= pl_b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0p <= r0[0];
      r1p <= r1[0];
      c0p <= c0[0];
      c1p <= c1[0];
      fa  <= qr[FRAC_BITS-1:0];
      fb  <= qc[FRAC_BITS-1:0];
    end
  end

  logic [PIX_W-1:0] blended;

  bls_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk   (clk),
    .en    (adv),
    .p00   (rd[{r0p, c0p}]),
    .p01   (rd[{r0p, c1p}]),
    .p10   (rd[{r1p, c0p}]),
    .p11   (rd[{r1p, c1p}]),
    .a     (fa),
    .b     (fb),
    .pixel (blended)
  );

  // Output register: zero the pixel for loads and out-of-range samples.
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (adv) rsp_valid <= pl_b2.vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out <= (!pl_b2.is_load && pl_b2.inr) ? blended : '0;
      in_range  <= pl_b2.inr;
    end
  end

  // At most one bank takes a write per cycle.
  a_one_bank_we: assert property (@(posedge clk) disable iff (rst) $onehot0(bank_we))
    else $error("more than one frame store bank written");

  // Sample neighbours never pass the frame edge.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    (pl_n.vld && !pl_n.is_load) |-> (r1 <= HMAX && c1 <= WMAX))
    else $error("neighbour index beyond frame edge");

  // A result outside the frame carries a zero pixel.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !in_range) |-> (pixel_out == '0))
    else $error("out-of-range result with nonzero pixel");

endmodule

/* src/bls_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* src/bls_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on bls_pkg (div_step).
module bls_div #(
  parameter int NW = 24
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [bls_pkg::SCALE_W-1:0]     s,
  input  logic [NW-1:0]                   num,
  output logic [NW-1:0]                   quo
);
  import bls_pkg::*;

  logic [SCALE_W-1:0] rem [0:NW];
  logic [NW-1:0]      nq  [0:NW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      nq[0]  <= num;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [SCALE_W:0] st;
    assign st = div_step(rem[k], nq[k][NW-1], s);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= st[SCALE_W-1:0];
        nq[k+1]  <= {nq[k][NW-2:0], st[SCALE_W]};
      end
    end
  end

  assign quo = nq[NW];

endmodule

/* src/bls_blend.sv */
// Bilinear blend of four RGB565 neighbours: weights, products, then sum.
// Depends on bls_pkg; two register stages, combinational packed result.
module bls_blend #(
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bls_pkg::PIX_W-1:0]   p00,
  input  logic [bls_pkg::PIX_W-1:0]   p01,
  input  logic [bls_pkg::PIX_W-1:0]   p10,
  input  logic [bls_pkg::PIX_W-1:0]   p11,
  input  logic [FRAC_BITS-1:0]        a,
  input  logic [FRAC_BITS-1:0]        b,
  output logic [bls_pkg::PIX_W-1:0]   pixel
);
  import bls_pkg::*;

  localparam int WW = 2 * FRAC_BITS + 1;
  localparam int PW = WW + 6;
  localparam int SW = PW + 2;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [WW-1:0]    w [0:3];
  logic [PIX_W-1:0] px [0:3];
  logic [PW-1:0]    pr [0:2][0:3];

  logic [FRAC_BITS:0] na, nb, ea, eb;
  logic [2*FRAC_BITS+1:0] m00, m01, m10, m11;

  assign ea = {1'b0, a};
  assign eb = {1'b0, b};
  assign na = ONE - ea;
  assign nb = ONE - eb;
  assign m00 = na * nb;
  assign m01 = na * eb;
  assign m10 = ea * nb;
  assign m11 = ea * eb;

  always_ff @(posedge clk) begin
    if (en) begin
      w[0]  <= m00[WW-1:0];
      w[1]  <= m01[WW-1:0];
      w[2]  <= m10[WW-1:0];
      w[3]  <= m11[WW-1:0];
      px[0] <= p00;
      px[1] <= p01;
      px[2] <= p10;
      px[3] <= p11;
    end
  end

  for (genvar n = 0; n < 4; n++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        pr[0][n] <= PW'(w[n]) * PW'(px[n][15:11]);
        pr[1][n] <= PW'(w[n]) * PW'(px[n][10:5]);
        pr[2][n] <= PW'(w[n]) * PW'(px[n][4:0]);
      end
    end
  end

  logic [SW-1:0] sum [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_sum
    assign sum[c] = SW'(pr[c][0]) + SW'(pr[c][1]) + SW'(pr[c][2]) + SW'(pr[c][3]);
  end

  assign pixel = {sum[0][2*FRAC_BITS +: 5], sum[1][2*FRAC_BITS +: 6],
                  sum[2][2*FRAC_BITS +: 5]};

endmodule

/* bench/bilinear_rgb565_scaler_test.sv */
// Self-checking bench for the bilinear RGB565 scaler: loads source pixels, samples
// scaled pixels under several scale settings and compares every response.
// Depends on bls_pkg and the bilinear_rgb565_scaler top level.
`timescale 1ns / 1ps

module bilinear_rgb565_scaler_test;
  import bls_pkg::*;

  localparam int H = 128;
  localparam int W = 128;
  localparam int FB = 8;
  localparam int DRAIN = 40;         // pipeline depth plus margin
  localparam longint CYCLE_LIMIT = 600000;

  // Frame mirror and expected-response store. Noting a transaction predicts
  // its response; checking pops the oldest prediction.
  class scaler_scoreboard;
    logic [15:0] frame[H*W];
    bit          loaded[H*W];
    logic [8:0]  scale_reg;
    logic [15:0] exp_pix[$];
    bit          exp_inr[$];

    function new();
      scale_reg = SCALE_RESET;
    endfunction

    function int unsigned eff();
      int unsigned s;
      s = scale_reg;
      if (s < SCALE_MIN) s = SCALE_MIN;
      if (s > SCALE_MAX) s = SCALE_MAX;
      return s;
    endfunction

    // Source indices of the four neighbours; returns 0 when outside the scaled frame.
    function bit taps(input int unsigned r, input int unsigned c, output int idx[4],
                      output longint unsigned fa, output longint unsigned fb);
      int unsigned s, r0, c0, r1, c1;
      longint unsigned pr, pc;
      s = eff();
      if (r >= H * s / 100 || c >= W * s / 100) return 0;
      pr = (longint'(r) * 100 * (1 << FB)) / s;
      pc = (longint'(c) * 100 * (1 << FB)) / s;
      r0 = pr >> FB;
      c0 = pc >> FB;
      fa = pr & ((1 << FB) - 1);
      fb = pc & ((1 << FB) - 1);
      r1 = (r0 + 1 > H - 1) ? H - 1 : r0 + 1;
      c1 = (c0 + 1 > W - 1) ? W - 1 : c0 + 1;
      if (r0 > H - 1) r0 = H - 1;
      if (c0 > W - 1) c0 = W - 1;
      idx[0] = r0 * W + c0;
      idx[1] = r0 * W + c1;
      idx[2] = r1 * W + c0;
      idx[3] = r1 * W + c1;
      return 1;
    endfunction

    function void unloaded(input int unsigned r, input int unsigned c, inout int q[$]);
      int idx[4];
      longint unsigned fa, fb;
      if (!taps(r, c, idx, fa, fb)) return;
      foreach (idx[k])
        if (!loaded[idx[k]] && !(idx[k] inside {q})) q.push_back(idx[k]);
    endfunction

    function logic [15:0] channel(input logic [15:0] p[4], input longint unsigned w[4],
                                  input int sh, input int unsigned mask);
      longint unsigned sum;
      sum = 0;
      foreach (p[k]) sum += w[k] * ((p[k] >> sh) & mask);
      return ((sum >> (2 * FB)) & mask) << sh;
    endfunction

    function void note(input func_t f, input int unsigned r, input int unsigned c,
                       input logic [15:0] pix);
      int idx[4];
      longint unsigned fa, fb;
      longint unsigned w[4];
      logic [15:0] p[4];
      if (f == FUNC_LOAD) begin
        if (r < H && c < W) begin
          frame[r*W + c] = pix;
          loaded[r*W + c] = 1;
        end
        exp_pix.push_back(16'h0);
        exp_inr.push_back(r < H && c < W);
        return;
      end
      if (!taps(r, c, idx, fa, fb)) begin
        exp_pix.push_back(16'h0);
        exp_inr.push_back(0);
        return;
      end
      w[0] = ((1 << FB) - fa) * ((1 << FB) - fb);
      w[1] = ((1 << FB) - fa) * fb;
      w[2] = fa * ((1 << FB) - fb);
      w[3] = fa * fb;
      foreach (p[k]) p[k] = frame[idx[k]];
      exp_pix.push_back(channel(p, w, 11, 'h1F) | channel(p, w, 5, 'h3F) |
                        channel(p, w, 0, 'h1F));
      exp_inr.push_back(1);
    endfunction

    function int pending();
      return exp_pix.size();
    endfunction

    // Returns an empty string on a match, else a description of the mismatch.
    function string check(input logic [15:0] pix, input logic inr);
      logic [15:0] ep;
      bit ei;
      if (exp_pix.size() == 0) return $sformatf("unexpected response pix=%h", pix);
      ep = exp_pix.pop_front();
      ei = exp_inr.pop_front();
      if (pix !== ep || inr !== ei)
        return $sformatf("pixel_out %h exp %h, in_range %b exp %b", pix, ep, inr, ei);
      return "";
    endfunction
  endclass

  logic        clk, rst;
  logic        req_valid, req_stall;
  logic        func;
  logic [8:0]  row, col;
  logic [15:0] pixel_in;
  logic        rsp_valid, rsp_stall;
  logic [15:0] pixel_out;
  logic        in_range;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;

  scaler_scoreboard sb = new();
  int     mismatches = 0;
  longint cycles = 0;
  bit     calm = 0;   // when set, neither side idles

  bilinear_rgb565_scaler dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .func(func), .row(row), .col(col), .pixel_in(pixel_in),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .pixel_out(pixel_out), .in_range(in_range),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog: bail out if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Idle length: mostly none or short, a few long ones.
  function int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Response-side stall: hold stall for random stretches, switch calm mode now and then.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      if ($urandom_range(0, 199) == 0) calm = ~calm;
      if (!calm && $urandom_range(0, 2) == 0) begin
        rsp_stall <= 1'b1;
        stall_left <= gap_len();
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Outputs are stable mid-cycle; a response seen here is taken at the next edge.
  always @(negedge clk) begin
    string msg;
    if (!rst && rsp_valid && !rsp_stall) begin
      msg = sb.check(pixel_out, in_range);
      if (msg != "") report(msg);
    end
  end

  // Drive one transaction, hold it until accepted, then optionally idle.
  task automatic send_one(input func_t f, input int unsigned r, input int unsigned c,
                          input logic [15:0] pix);
    bit taken;
    int unsigned g;
    req_valid <= 1'b1;
    func      <= f;
    row       <= 9'(r);
    col       <= 9'(c);
    pixel_in  <= pix;
    do begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
    end while (!taken);
    sb.note(f, r, c, pix);
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Send a transaction; a sample first gets any unloaded neighbours filled in.
  task automatic send(input func_t f, input int unsigned r, input int unsigned c,
                      input logic [15:0] pix);
    int q[$];
    if (f == FUNC_SAMPLE) sb.unloaded(r, c, q);
    foreach (q[k])
      send_one(FUNC_LOAD, q[k] / W, q[k] % W, 16'($urandom_range(0, 16'hFFFF)));
    send_one(f, r, c, pix);
  endtask

  // Drain everything outstanding, then write the scale register.
  task automatic set_scale(input logic [8:0] v);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.scale_reg = v;
  endtask

  task automatic random_items(input int n);
    int unsigned s, oh, ow, r, c;
    repeat (n) begin
      s  = sb.eff();
      oh = H * s / 100;
      ow = W * s / 100;
      if ($urandom_range(0, 9) < 4) begin
        r = ($urandom_range(0, 4) != 0) ? $urandom_range(0, H - 1) : $urandom_range(0, 511);
        c = ($urandom_range(0, 4) != 0) ? $urandom_range(0, W - 1) : $urandom_range(0, 511);
        send(FUNC_LOAD, r, c, 16'($urandom_range(0, 16'hFFFF)));
      end else begin
        r = ($urandom_range(0, 6) != 0) ? $urandom_range(0, oh - 1) : $urandom_range(0, 511);
        c = ($urandom_range(0, 6) != 0) ? $urandom_range(0, ow - 1) : $urandom_range(0, 511);
        send(FUNC_SAMPLE, r, c, 16'($urandom_range(0, 16'hFFFF)));
      end
    end
  endtask

  initial begin
    logic [8:0] scales[$] = '{9'd25, 9'd400, 9'd0, 9'd511, 9'd37, 9'd233, 9'd399, 9'd26};
    rst       = 1'b1;
    req_valid = 1'b0;
    func      = FUNC_LOAD;
    row       = '0;
    col       = '0;
    pixel_in  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corner loads, loads off the frame, samples at the edges.
    set_scale(9'd100);
    send(FUNC_LOAD, 0, 0, 16'h0000);
    send(FUNC_LOAD, 127, 127, 16'hFFFF);
    send(FUNC_LOAD, 0, 127, 16'hF800);
    send(FUNC_LOAD, 127, 0, 16'h07E0);
    send(FUNC_LOAD, 5, 5, 16'h001F);
    send(FUNC_LOAD, 128, 0, 16'hFFFF);
    send(FUNC_LOAD, 0, 128, 16'hAAAA);
    send(FUNC_LOAD, 511, 511, 16'h5555);
    send(FUNC_SAMPLE, 0, 0, 16'h0);
    send(FUNC_SAMPLE, 127, 127, 16'hFFFF);
    send(FUNC_SAMPLE, 64, 64, 16'h0);
    send(FUNC_SAMPLE, 128, 0, 16'h0);
    send(FUNC_SAMPLE, 0, 511, 16'h0);
    send(FUNC_SAMPLE, 511, 511, 16'h0);
    set_scale(9'd400);
    send(FUNC_SAMPLE, 511, 511, 16'h0);   // clamped neighbours at the far corner
    send(FUNC_SAMPLE, 1, 3, 16'h0);
    send(FUNC_SAMPLE, 0, 511, 16'h0);
    set_scale(9'd25);
    send(FUNC_SAMPLE, 31, 31, 16'h0);
    send(FUNC_SAMPLE, 32, 0, 16'h0);
    send(FUNC_SAMPLE, 0, 32, 16'h0);

    // Random phases; each scale change drains the pipeline first. Most samples
    // pull in a few neighbour loads, so the phases stay short.
    set_scale(9'd100);
    random_items(30);
    scales.push_back(9'($urandom_range(0, 511)));
    foreach (scales[k]) begin
      set_scale(scales[k]);
      random_items(26);
    end

    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
